FILE: src/gf2m_poly_divider_top_defines.svh
// assertion macros for the gf2m polynomial divider
// included by files that carry concurrent checks; no other dependencies
`ifndef GF2M_POLY_DIVIDER_TOP_DEFINES_SVH
`define GF2M_POLY_DIVIDER_TOP_DEFINES_SVH

// condition must never hold outside reset
`define GPD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

// antecedent implies consequent in the following cycle
`define GPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/gpd_pkg.sv
// shared types, codes and gf(2^m) multiply for the polynomial divider
// no dependencies
package gpd_pkg;

    localparam int SYM_BITS       = 8;
    localparam int FP_W           = SYM_BITS + 1;
    localparam int POS_W          = 12;
    localparam int LEN_W          = POS_W + 1;
    localparam int MAX_DEG_DEF    = 32;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic [FP_W-1:0]  FIELD_POLY_RST = FP_W'(285);
    localparam logic [POS_W-1:0] DIV_LEN_RST    = POS_W'(255);

    // register index (paddr bit 2)
    localparam logic REG_FIELD_POLY = 1'b0;
    localparam logic REG_DIV_LEN    = 1'b1;

    // request opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DATA = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_QUOT = 2'd0;
    localparam logic [1:0] KIND_REM  = 2'd1;
    localparam logic [1:0] KIND_DIV0 = 2'd2;

    typedef struct packed {
        logic                op;
        logic [SYM_BITS-1:0] coef;
        logic                last;
    } t_req;

    typedef struct packed {
        logic [1:0]          kind;
        logic [SYM_BITS-1:0] value;
        logic                final_res;
    } t_res;

    // control broadcast from the top to every cell of the chain
    typedef struct packed {
        logic                clear;
        logic                step;
        logic                quot;
        logic [SYM_BITS-1:0] qc;
        logic [FP_W-1:0]     poly;
        logic                wr_en;
        logic [SYM_BITS-1:0] wr_data;
    } t_cell_ctrl;

    // msb-first shift and add, reduced by the low bits of poly
    function automatic logic [SYM_BITS-1:0] gf_mul(
        input logic [SYM_BITS-1:0] a,
        input logic [SYM_BITS-1:0] b,
        input logic [FP_W-1:0]     poly
    );
        logic [SYM_BITS:0] acc;
        acc = '0;
        for (int i = SYM_BITS - 1; i >= 0; i--) begin
            acc = {acc[SYM_BITS-1:0], 1'b0};
            if (acc[SYM_BITS]) begin
                acc = {1'b0, acc[SYM_BITS-1:0] ^ poly[SYM_BITS-1:0]};
            end
            if (b[i]) begin
                acc = acc ^ {1'b0, a};
            end
        end
        return acc[SYM_BITS-1:0];
    endfunction

endpackage

FILE: src/gpd_stream_if.sv
// valid/ready stream channel with a typed payload
// no dependencies; payload type is set where the channel is instantiated
interface gpd_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/gpd_inv.sv
// multi-cycle inverse unit: a^(2^m - 2) by alternating square and multiply
// depends on gpd_pkg
module gpd_inv
    import gpd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SYM_BITS-1:0] i_operand,
    input  logic [FP_W-1:0]     i_field_poly,
    output logic                o_busy,
    output logic [SYM_BITS-1:0] o_inverse
);
    localparam int STEPS = 2 * (SYM_BITS - 1);
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [FP_W-1:0]     r_poly;
    logic [SYM_BITS-1:0] r_sq;
    logic [SYM_BITS-1:0] r_acc;
    logic [SYM_BITS-1:0] prod;

    // even steps square, odd steps fold the square into the result
    assign prod = gf_mul(r_cnt[0] ? r_acc : r_sq, r_sq, r_poly);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_poly <= i_field_poly;
            r_sq   <= i_operand;
            r_acc  <= SYM_BITS'(1);
        end else if (r_busy) begin
            if (r_cnt[0]) begin
                r_acc <= prod;
            end else begin
                r_sq <= prod;
            end
        end
    end

    assign o_busy    = r_busy;
    assign o_inverse = r_acc;
endmodule

FILE: src/gpd_cell.sv
// one cell of the division chain: a divisor coefficient and one window term
// depends on gpd_pkg
module gpd_cell
    import gpd_pkg::*;
#(
    parameter int IDX   = 1,
    parameter int DEG_W = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctrl          i_ctrl,
    input  logic [DEG_W-1:0]    i_deg,
    input  logic [DEG_W-1:0]    i_wr_idx,
    input  logic [SYM_BITS-1:0] i_next_w,
    output logic [SYM_BITS-1:0] o_w
);
    logic [SYM_BITS-1:0] r_s;
    logic [SYM_BITS-1:0] r_w;
    logic [SYM_BITS-1:0] n_w;
    logic [SYM_BITS-1:0] prod;
    logic                act;
    logic                has_next;

    always_comb begin
        act      = DEG_W'(IDX) <= i_deg;
        has_next = DEG_W'(IDX) < i_deg;
        prod     = gf_mul(r_s, i_ctrl.qc, i_ctrl.poly);
        n_w      = r_w;
        if (i_ctrl.clear) begin
            n_w = '0;
        end else if (i_ctrl.step && act) begin
            // shift in the neighbor's term, subtract divisor times quotient
            n_w = (has_next ? i_next_w : '0) ^ (i_ctrl.quot ? prod : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= '0;
        end else begin
            r_w <= n_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en && (i_wr_idx == DEG_W'(IDX))) begin
            r_s <= i_ctrl.wr_data;
        end
    end

    assign o_w = r_w;
endmodule

FILE: src/gf2m_poly_divider_top.sv
// top level of the streaming gf(2^m) polynomial divider
// depends on gpd_pkg, gpd_stream_if, gpd_inv, gpd_cell and the defines header
//
// usage
//   i_req carries requests {op, coef, last}. op load brings divisor
//   coefficients highest first, last closes the divisor. op data streams
//   dividend coefficients highest first, dividend_length of them per division.
//   o_res carries results {kind, value, final_res}: quotient terms, then the
//   remainder with leading zeros dropped, or a divide-by-zero marker.
//   apb port: field_poly at byte 0, dividend_length at byte 4; pready is tied
//   high, write data lands on the access cycle.
// timing
//   a data request with a nonzero divisor loaded: the accept cycle forms v
//   and the quotient term, the next cycle steps the whole cell chain, and
//   requests are held off meanwhile. with no nonzero divisor there is no
//   chain step. results enter the result queue at the accept edge and can
//   leave after it. a load request holds nothing off, except the first
//   nonzero divisor term, which holds requests off while the inverse unit
//   runs its square and multiply sequence.
// reset
//   no divisor loaded, window cleared, field_poly 285, dividend_length 255.
// stall
//   a 4-entry result queue sits in front of o_res; requests are held off
//   while fewer than two entries are free.
`include "gf2m_poly_divider_top_defines.svh"

module gf2m_poly_divider_top
    import gpd_pkg::*;
#(
    parameter int MAX_DIVISOR_DEGREE = MAX_DEG_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gpd_stream_if.sink            i_req,
    gpd_stream_if.source          o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    localparam int DEG_W      = $clog2(MAX_DIVISOR_DEGREE + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // config registers
    logic [FP_W-1:0]  r_field_poly;
    logic [POS_W-1:0] r_div_len;

    // divisor and dividend progress
    logic             r_loaded_nz;
    logic [DEG_W-1:0] r_deg;
    logic             r_closed;
    logic [POS_W-1:0] r_pos;
    logic             r_seen;

    // window step stage
    logic                r_stb;
    logic                r_quot;
    logic                r_end;
    logic [SYM_BITS-1:0] r_qc;

    // result queue
    t_res             r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;

    t_req                req;
    logic                accept;
    logic                is_load;
    logic                pop;
    logic [1:0]          push_n;
    t_res                res_a;
    t_res                res_b;
    t_res                slot0;
    t_res                slot1;
    logic                va;
    logic                vb;
    logic [LEN_W-1:0]    len_eff;
    logic [LEN_W-1:0]    pos_ext;
    logic                is_end;
    logic                is_quot;
    logic                is_first;
    logic [SYM_BITS-1:0] win_head;
    logic [SYM_BITS-1:0] v;
    logic [SYM_BITS-1:0] qc;
    logic                ld_nz_base;
    logic [DEG_W-1:0]    deg_base;
    logic                load_wr;
    logic [DEG_W-1:0]    wr_idx;
    logic                inv_go;
    logic                inv_busy;
    logic [SYM_BITS-1:0] lead_inv;
    logic                cfg_wr;
    t_cell_ctrl          cell_ctrl;
    logic [SYM_BITS-1:0] w_chain [1:MAX_DIVISOR_DEGREE+1];

    assign req     = i_req.payload;
    assign accept  = i_req.valid && i_req.ready;
    assign is_load = req.op == OP_LOAD;
    assign pop     = o_res.valid && o_res.ready;

    // hold requests during the chain step, the inverse run, or a full queue
    assign i_req.ready = !r_stb && !inv_busy && (r_cnt <= CNT_W'(FIFO_DEPTH - 2));

    // apb register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[2])
            REG_FIELD_POLY: prdata = APB_DATA_W'(r_field_poly);
            REG_DIV_LEN:    prdata = APB_DATA_W'(r_div_len);
            default:        prdata = '0;
        endcase
    end

    // divisor loading: a load after a closed divisor starts over
    always_comb begin
        ld_nz_base = r_closed ? 1'b0 : r_loaded_nz;
        deg_base   = r_closed ? '0 : r_deg;
        load_wr    = ld_nz_base && (deg_base < DEG_W'(MAX_DIVISOR_DEGREE));
        wr_idx     = deg_base + DEG_W'(1);
        inv_go     = accept && is_load && !ld_nz_base && (req.coef != '0);
    end

    // dividend step decode; length zero means 4096
    always_comb begin
        len_eff  = (r_div_len == '0) ? {1'b1, {POS_W{1'b0}}} : {1'b0, r_div_len};
        pos_ext  = {1'b0, r_pos};
        is_end   = (pos_ext + LEN_W'(1)) >= len_eff;
        is_quot  = (pos_ext + LEN_W'(r_deg)) < len_eff;
        is_first = (r_pos == '0) && !is_quot;
        win_head = (r_deg == '0) ? '0 : w_chain[1];
        v        = req.coef ^ win_head;
        qc       = gf_mul(v, lead_inv, r_field_poly);

        va              = 1'b0;
        vb              = 1'b0;
        res_a.kind      = KIND_QUOT;
        res_a.value     = qc;
        res_a.final_res = 1'b0;
        res_b.kind      = KIND_REM;
        res_b.value     = '0;
        res_b.final_res = 1'b1;
        if (!r_loaded_nz) begin
            // no usable divisor: one error marker when the dividend ends
            va              = is_end;
            res_a.kind      = KIND_DIV0;
            res_a.value     = '0;
            res_a.final_res = 1'b1;
        end else if (is_quot) begin
            va = 1'b1;
            // degree zero divisor closes with a zero remainder
            vb = (r_deg == '0) && is_end;
        end else begin
            // remainder terms; a dividend shorter than the divisor gets a lone zero quotient first
            va              = is_first;
            res_a.value     = '0;
            vb              = (v != '0) || r_seen || is_end;
            res_b.value     = v;
            res_b.final_res = is_end;
        end

        slot0  = va ? res_a : res_b;
        slot1  = res_b;
        push_n = (accept && !is_load) ? (2'(va) + 2'(vb)) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_poly <= FIELD_POLY_RST;
            r_div_len    <= DIV_LEN_RST;
            r_loaded_nz  <= 1'b0;
            r_deg        <= '0;
            r_closed     <= 1'b1;
            r_pos        <= '0;
            r_seen       <= 1'b0;
            r_stb        <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_cnt        <= '0;
        end else begin
            if (cfg_wr) begin
                case (paddr[2])
                    REG_FIELD_POLY: r_field_poly <= pwdata[FP_W-1:0];
                    REG_DIV_LEN:    r_div_len    <= pwdata[POS_W-1:0];
                    default:        r_div_len    <= r_div_len;
                endcase
            end

            r_stb <= accept && !is_load && r_loaded_nz;

            if (accept) begin
                if (is_load) begin
                    r_closed <= req.last;
                    r_pos    <= '0;
                    r_seen   <= 1'b0;
                    if (!ld_nz_base) begin
                        r_loaded_nz <= req.coef != '0;
                        r_deg       <= '0;
                    end else if (load_wr) begin
                        r_deg <= wr_idx;
                    end
                end else begin
                    if (is_end) begin
                        r_pos  <= '0;
                        r_seen <= 1'b0;
                    end else begin
                        r_pos <= r_pos + POS_W'(1);
                        if (r_loaded_nz && !is_quot && (v != '0)) begin
                            r_seen <= 1'b1;
                        end
                    end
                end
            end

            r_wr_ptr <= r_wr_ptr + PTR_W'(push_n);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_cnt    <= r_cnt + CNT_W'(push_n) - CNT_W'(pop);
        end
    end

    // step stage and queue payload
    always_ff @(posedge i_clk) begin
        if (accept && !is_load) begin
            r_quot <= is_quot;
            r_end  <= is_end;
            r_qc   <= qc;
        end
        for (int e = 0; e < FIFO_DEPTH; e++) begin
            if ((push_n != 2'd0) && (r_wr_ptr == PTR_W'(e))) begin
                r_fifo[e] <= slot0;
            end else if ((push_n == 2'd2) && ((r_wr_ptr + PTR_W'(1)) == PTR_W'(e))) begin
                r_fifo[e] <= slot1;
            end
        end
    end

    assign o_res.valid   = r_cnt != '0;
    assign o_res.payload = r_fifo[r_rd_ptr];

    // leading divisor term inverse
    gpd_inv u_inv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (inv_go),
        .i_operand    (req.coef),
        .i_field_poly (r_field_poly),
        .o_busy       (inv_busy),
        .o_inverse    (lead_inv)
    );

    // cell chain: window clears on any load and at the end of a dividend
    always_comb begin
        cell_ctrl.clear   = (accept && is_load) || (r_stb && r_end);
        cell_ctrl.step    = r_stb;
        cell_ctrl.quot    = r_quot;
        cell_ctrl.qc      = r_qc;
        cell_ctrl.poly    = r_field_poly;
        cell_ctrl.wr_en   = accept && is_load && load_wr;
        cell_ctrl.wr_data = req.coef;
    end

    assign w_chain[MAX_DIVISOR_DEGREE+1] = '0;

    for (genvar k = 1; k <= MAX_DIVISOR_DEGREE; k++) begin : g_cell
        gpd_cell #(
            .IDX   (k),
            .DEG_W (DEG_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (cell_ctrl),
            .i_deg    (r_deg),
            .i_wr_idx (wr_idx),
            .i_next_w (w_chain[k+1]),
            .o_w      (w_chain[k])
        );
    end

    // checks
    `GPD_ASSERT_NEVER(a_queue_overflow, i_clk, i_rst_n, r_cnt > CNT_W'(FIFO_DEPTH), "result queue overflow")
    `GPD_ASSERT_NEXT(a_step_single, i_clk, i_rst_n, r_stb, !r_stb, "chain step lasted more than one cycle")
    `GPD_ASSERT_NEXT(a_inv_running, i_clk, i_rst_n, inv_go, inv_busy, "inverse unit did not start")
    `GPD_ASSERT_NEXT(a_win_cleared, i_clk, i_rst_n, r_stb && r_end, w_chain[1] == '0, "window not cleared at dividend end")
endmodule

FILE: bench/gf2m_poly_divider_top_tb.sv
// self-checking bench for the streaming gf(2^m) polynomial divider
// depends on gpd_pkg, gpd_stream_if and gf2m_poly_divider_top from the rtl tree
`timescale 1ns / 100ps

module gf2m_poly_divider_top_tb;
    import gpd_pkg::*;

    localparam int MAX_DEG       = MAX_DEG_DEF;
    // covers the inverse sequence of a first divisor term plus the data pipe
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RUN_LIMIT_NS  = 20_000_000;

    // ------------------------------------------------------------------
    // clock, reset, channels, apb port
    // ------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    gpd_stream_if #(.t_payload(t_req)) req_if ();
    gpd_stream_if #(.t_payload(t_res)) res_if ();

    gf2m_poly_divider_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // divider shadow state
    // ------------------------------------------------------------------
    // register copies
    logic [FP_W-1:0]     cfg_poly;
    logic [POS_W-1:0]    cfg_len;
    // divisor: coefficients from the leading term down, its degree, inverse of lead
    logic [SYM_BITS-1:0] dsr_coef [0:MAX_DEG];
    int unsigned         dsr_deg;
    bit                  dsr_valid;
    bit                  dsr_closed;
    logic [SYM_BITS-1:0] dsr_lead_inv;
    // running dividend: partial remainders still to fold in, position, zero suppress
    logic [SYM_BITS-1:0] rem_window [0:MAX_DEG-1];
    int unsigned         div_pos;
    bit                  rem_started;

    // quotient / remainder terms owed by the block, oldest first
    t_res        div_results_q[$];
    int unsigned req_cnt;
    int unsigned err_cnt;
    // random idling on both channels
    bit          gaps_on;

    // multiply in the ring gf(2)[x] / (x^m + low bits of field_poly), lsb first
    function automatic logic [SYM_BITS-1:0] field_mul(input logic [SYM_BITS-1:0] a,
                                                      input logic [SYM_BITS-1:0] b);
        logic [SYM_BITS-1:0] x;
        logic [SYM_BITS-1:0] acc;
        x   = a;
        acc = '0;
        for (int i = 0; i < SYM_BITS; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            x = {x[SYM_BITS-2:0], 1'b0} ^ (x[SYM_BITS-1] ? cfg_poly[SYM_BITS-1:0] : '0);
        end
        return acc;
    endfunction

    // a^(2^m - 2), built up one factor at a time
    function automatic logic [SYM_BITS-1:0] field_inv(input logic [SYM_BITS-1:0] a);
        logic [SYM_BITS-1:0] acc;
        acc = SYM_BITS'(1);
        repeat ((1 << SYM_BITS) - 2) acc = field_mul(acc, a);
        return acc;
    endfunction

    function automatic void clear_dividend();
        div_pos     = 0;
        rem_started = 1'b0;
        for (int k = 0; k < MAX_DEG; k++) rem_window[k] = '0;
    endfunction

    function automatic void push_term(input logic [1:0] kind,
                                      input logic [SYM_BITS-1:0] value, input logic fin);
        t_res e;
        e.kind      = kind;
        e.value     = value;
        e.final_res = fin;
        div_results_q.push_back(e);
    endfunction

    // advance the shadow divider by one accepted request
    function automatic void divide_step(input t_req r);
        int unsigned         eff_len;
        int unsigned         d;
        int unsigned         qlen;
        logic [SYM_BITS-1:0] v;
        logic [SYM_BITS-1:0] qc;
        bit                  at_end;
        if (r.op == OP_LOAD) begin
            // a closed divisor is replaced, any running dividend is dropped
            if (dsr_closed) begin
                dsr_valid  = 1'b0;
                dsr_deg    = 0;
                dsr_closed = 1'b0;
            end
            clear_dividend();
            if (!dsr_valid) begin
                // leading zeros are skipped
                if (r.coef != '0) begin
                    dsr_coef[0]  = r.coef;
                    dsr_lead_inv = field_inv(r.coef);
                    dsr_valid    = 1'b1;
                    dsr_deg      = 0;
                end
            end else if (dsr_deg < MAX_DEG) begin
                // terms past the maximum degree are dropped
                dsr_deg++;
                dsr_coef[dsr_deg] = r.coef;
            end
            if (r.last) begin
                dsr_closed = 1'b1;
            end
        end else begin
            eff_len = (cfg_len == '0) ? 4096 : int'(cfg_len);
            at_end  = (div_pos + 1 >= eff_len);
            if (!dsr_valid) begin
                // no divisor: only the closing term reports divide by zero
                if (at_end) begin
                    push_term(KIND_DIV0, '0, 1'b1);
                end
            end else begin
                d    = dsr_deg;
                qlen = (eff_len > d) ? eff_len - d : 0;
                v    = r.coef;
                if (d > 0) begin
                    v = v ^ rem_window[0];
                    for (int unsigned k = 0; k + 1 < d; k++) rem_window[k] = rem_window[k + 1];
                    rem_window[d - 1] = '0;
                end
                if (div_pos < qlen) begin
                    qc = field_mul(v, dsr_lead_inv);
                    push_term(KIND_QUOT, qc, 1'b0);
                    for (int unsigned k = 1; k <= d; k++) begin
                        rem_window[k - 1] = rem_window[k - 1] ^ field_mul(dsr_coef[k], qc);
                    end
                    // degree zero divisor leaves a zero remainder
                    if (d == 0 && at_end) begin
                        push_term(KIND_REM, '0, 1'b1);
                    end
                end else begin
                    // dividend shorter than divisor: quotient is zero
                    if (div_pos == 0 && qlen == 0) begin
                        push_term(KIND_QUOT, '0, 1'b0);
                    end
                    if (v != '0 || rem_started) begin
                        rem_started = 1'b1;
                        push_term(KIND_REM, v, at_end);
                    end else if (at_end) begin
                        push_term(KIND_REM, '0, 1'b1);
                    end
                end
            end
            if (at_end) begin
                clear_dividend();
            end else begin
                div_pos++;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // result side: ready with random stalls, and the checker
    // ------------------------------------------------------------------
    initial begin : res_ready_drv
        int unsigned n;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (gaps_on && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 6);
                res_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
        end
    end

    // each accepted result against the oldest owed term
    always @(posedge i_clk) begin : result_check
        t_res got;
        t_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.payload;
            if (div_results_q.size() == 0) begin
                $error("unexpected result: kind %0d value %0h final_res %0b",
                       got.kind, got.value, got.final_res);
                err_cnt++;
            end else begin
                want = div_results_q.pop_front();
                if (got.kind !== want.kind) begin
                    $error("kind mismatch: expected %0d, actual %0d", want.kind, got.kind);
                    err_cnt++;
                end
                if (got.value !== want.value) begin
                    $error("value mismatch: expected %0h, actual %0h", want.value, got.value);
                    err_cnt++;
                end
                if (got.final_res !== want.final_res) begin
                    $error("final_res mismatch: expected %0b, actual %0b",
                           want.final_res, got.final_res);
                    err_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // request side and register access
    // ------------------------------------------------------------------
    // one request; valid stays high afterwards so back to back requests flow
    task automatic send_req(input logic op, input logic [SYM_BITS-1:0] coef,
                            input logic last);
        t_req        r;
        int unsigned gap;
        r.op   = op;
        r.coef = coef;
        r.last = last;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do @(posedge i_clk); while (!req_if.ready);
        divide_step(r);
        req_cnt++;
    endtask

    task automatic wait_drained();
        int unsigned guard;
        guard = 0;
        while (div_results_q.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (div_results_q.size() != 0) begin
            $error("%0d expected results never arrived", div_results_q.size());
            err_cnt++;
            div_results_q.delete();
        end
    endtask

    // registers change only with the divider quiet
    task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] data);
        req_if.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_FIELD_POLY) begin
            cfg_poly = data[FP_W-1:0];
        end else begin
            cfg_len = data[POS_W-1:0];
        end
    endtask

    function automatic logic [SYM_BITS-1:0] rand_coef();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        if (sel < 2) begin
            return '0;
        end else if (sel == 2) begin
            return '1;
        end
        return SYM_BITS'($urandom_range(0, (1 << SYM_BITS) - 1));
    endfunction

    function automatic logic [SYM_BITS-1:0] nonzero_coef();
        return SYM_BITS'($urandom_range(1, (1 << SYM_BITS) - 1));
    endfunction

    // mostly low degrees, some past the maximum to hit truncation
    function automatic int unsigned pick_degree();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(0, 6);
        end
        return $urandom_range(7, MAX_DEG + 3);
    endfunction

    task automatic load_divisor(input int unsigned deg, input int unsigned lead_zeros);
        for (int unsigned k = 0; k < lead_zeros; k++) send_req(OP_LOAD, '0, 1'b0);
        send_req(OP_LOAD, nonzero_coef(), deg == 0);
        for (int unsigned k = 1; k <= deg; k++) send_req(OP_LOAD, rand_coef(), k == deg);
    endtask

    task automatic load_zero_divisor(input int unsigned n);
        for (int unsigned k = 1; k <= n; k++) send_req(OP_LOAD, '0, k == n);
    endtask

    // dividend terms; the last bit is don't-care here, so it is random
    task automatic send_dividend(input int unsigned n);
        repeat (n) send_req(OP_DATA, rand_coef(), 1'($urandom_range(0, 1)));
    endtask

    task automatic random_config();
        int unsigned      sel;
        logic [FP_W-1:0]  fp;
        logic [POS_W-1:0] ln;
        sel = $urandom_range(0, 5);
        case (sel)
            0, 1, 2: begin
                fp = FIELD_POLY_RST;
            end
            3: begin
                fp = FP_W'(256 + $urandom_range(0, 255));
            end
            4: begin
                fp = FP_W'($urandom_range(0, 511));
            end
            default: begin
                fp = FP_W'(299);
            end
        endcase
        sel = $urandom_range(0, 7);
        ln  = (sel < 6) ? POS_W'($urandom_range(1, 16)) : POS_W'($urandom_range(17, 48));
        write_reg(REG_FIELD_POLY, APB_DATA_W'(fp));
        write_reg(REG_DIV_LEN, APB_DATA_W'(ln));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // reset values: field 285, 255 term dividends
    task automatic test_reset_defaults();
        send_req(OP_LOAD, 8'h01, 1'b0);
        send_req(OP_LOAD, 8'h02, 1'b0);
        send_req(OP_LOAD, 8'h03, 1'b1);
        send_dividend(255);
    endtask

    // leading zeros in the divisor, extreme coefficients in the dividend
    task automatic test_basic_division();
        write_reg(REG_DIV_LEN, 32'd6);
        send_req(OP_LOAD, 8'h00, 1'b0);
        send_req(OP_LOAD, 8'h00, 1'b0);
        send_req(OP_LOAD, 8'hff, 1'b0);
        send_req(OP_LOAD, 8'h01, 1'b0);
        send_req(OP_LOAD, 8'h80, 1'b1);
        send_req(OP_DATA, 8'hff, 1'b0);
        send_req(OP_DATA, 8'h00, 1'b1);
        send_req(OP_DATA, 8'h01, 1'b0);
        send_req(OP_DATA, 8'hff, 1'b0);
        send_req(OP_DATA, 8'h80, 1'b0);
        send_req(OP_DATA, 8'h00, 1'b1);
    endtask

    // constant divisor: every term is a quotient, then a zero remainder
    task automatic test_degree_zero();
        write_reg(REG_DIV_LEN, 32'd2);
        send_req(OP_LOAD, 8'h07, 1'b1);
        send_req(OP_DATA, 8'hff, 1'b0);
        send_req(OP_DATA, 8'h01, 1'b0);
        // single term dividend gives two results on one request
        write_reg(REG_DIV_LEN, 32'd1);
        send_req(OP_DATA, 8'h00, 1'b0);
    endtask

    // dividend not longer than the divisor degree comes back as remainder
    task automatic test_short_dividend();
        write_reg(REG_DIV_LEN, 32'd2);
        send_req(OP_LOAD, 8'h01, 1'b0);
        send_req(OP_LOAD, 8'h02, 1'b0);
        send_req(OP_LOAD, 8'h03, 1'b1);
        send_req(OP_DATA, 8'h00, 1'b0);
        send_req(OP_DATA, 8'h05, 1'b0);
        send_req(OP_DATA, 8'h09, 1'b0);
        send_req(OP_DATA, 8'h00, 1'b0);
    endtask

    task automatic test_zero_divisor();
        send_req(OP_LOAD, 8'h00, 1'b0);
        send_req(OP_LOAD, 8'h00, 1'b1);
        send_req(OP_DATA, 8'hff, 1'b0);
        send_req(OP_DATA, 8'h01, 1'b1);
    endtask

    // overlong divisor, data while the divisor is open, load mid dividend
    task automatic test_divisor_corners();
        write_reg(REG_DIV_LEN, 32'd36);
        load_divisor(MAX_DEG + 3, 0);
        send_dividend(36);
        write_reg(REG_DIV_LEN, 32'd4);
        send_req(OP_LOAD, 8'h05, 1'b0);
        send_req(OP_LOAD, 8'h06, 1'b0);
        send_req(OP_DATA, 8'h01, 1'b0);
        send_req(OP_DATA, 8'h02, 1'b0);
        // closes the divisor and drops the half-done dividend
        send_req(OP_LOAD, 8'h07, 1'b1);
        send_dividend(4);
    endtask

    // length rewritten between terms of one dividend
    task automatic test_length_change();
        write_reg(REG_DIV_LEN, 32'd10);
        send_req(OP_LOAD, 8'h03, 1'b0);
        send_req(OP_LOAD, 8'h04, 1'b1);
        send_dividend(5);
        // shrink below the position: the next term closes it
        write_reg(REG_DIV_LEN, 32'd3);
        send_dividend(1);
        send_dividend(3);
        write_reg(REG_DIV_LEN, 32'd20);
        send_dividend(4);
        write_reg(REG_DIV_LEN, 32'd40);
        send_dividend(36);
    endtask

    // degenerate field polynomials; the stored inverse outlives a field change
    task automatic test_field_extremes();
        write_reg(REG_DIV_LEN, 32'd5);
        write_reg(REG_FIELD_POLY, 32'd0);
        send_req(OP_LOAD, 8'h03, 1'b0);
        send_req(OP_LOAD, 8'h05, 1'b0);
        send_req(OP_LOAD, 8'h07, 1'b1);
        send_dividend(5);
        write_reg(REG_FIELD_POLY, 32'd511);
        send_dividend(5);
        load_divisor(2, 0);
        send_dividend(5);
        write_reg(REG_FIELD_POLY, APB_DATA_W'(FIELD_POLY_RST));
    endtask

    // shortest length, longest length, and zero standing for 4096
    task automatic test_length_extremes();
        write_reg(REG_DIV_LEN, 32'd1);
        load_divisor(3, 0);
        send_dividend(4);
        // long lengths: the opening terms stay quotients, a load cuts them off
        write_reg(REG_DIV_LEN, 32'd4095);
        load_divisor(MAX_DEG, 0);
        send_dividend(40);
        write_reg(REG_DIV_LEN, 32'd0);
        load_divisor(4, 1);
        send_dividend(40);
        // shrinking the length closes the long dividend on the next term
        write_reg(REG_DIV_LEN, 32'd2);
        send_dividend(1);
    endtask

    // mostly whole divisions, plus cut dividends, open divisors and noise
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned start;
        int unsigned phase_start;
        int unsigned pick;
        int unsigned n;
        int unsigned eff;
        start       = req_cnt;
        phase_start = req_cnt;
        random_config();
        while (req_cnt - start < n_items) begin
            if (req_cnt - phase_start > 150) begin
                random_config();
                phase_start = req_cnt;
            end
            eff  = (cfg_len == '0) ? 4096 : int'(cfg_len);
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                load_divisor(pick_degree(),
                             ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
                n = $urandom_range(1, 3);
                repeat (n) send_dividend(eff);
            end else if (pick == 6) begin
                load_zero_divisor($urandom_range(1, 3));
                send_dividend(eff);
            end else if (pick == 7) begin
                // dividend cut off by the next divisor
                send_dividend($urandom_range(1, eff));
                load_divisor(pick_degree(), 0);
            end else if (pick == 8) begin
                // dividend terms while the divisor is still open
                n = $urandom_range(1, 4);
                send_req(OP_LOAD, nonzero_coef(), 1'b0);
                repeat (n - 1) send_req(OP_LOAD, rand_coef(), 1'b0);
                send_dividend($urandom_range(1, eff));
                send_req(OP_LOAD, rand_coef(), 1'b1);
            end else begin
                n = $urandom_range(1, 8);
                repeat (n) send_req(1'($urandom_range(0, 1)), rand_coef(),
                                    1'($urandom_range(0, 1)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin : stim
        // inputs known from time zero
        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        // shadow state as after reset
        cfg_poly     = FIELD_POLY_RST;
        cfg_len      = DIV_LEN_RST;
        dsr_deg      = 0;
        dsr_valid    = 1'b0;
        dsr_closed   = 1'b1;
        dsr_lead_inv = '0;
        for (int k = 0; k <= MAX_DEG; k++) dsr_coef[k] = '0;
        clear_dividend();
        req_cnt = 0;
        err_cnt = 0;
        gaps_on = 1'b1;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_basic_division();
        test_degree_zero();
        test_short_dividend();
        test_zero_divisor();
        test_divisor_corners();
        test_length_change();
        test_field_extremes();
        test_random_traffic(300);
        // a stretch with both sides running flat out
        gaps_on = 1'b0;
        test_random_traffic(150);
        gaps_on = 1'b1;
        test_random_traffic(150);
        test_length_extremes();
        // closing part without idling
        gaps_on = 1'b0;
        test_random_traffic(100);

        req_if.valid <= 1'b0;
        wait_drained();
        // catch any stray result after the last owed one
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("gf2m_poly_divider_top test passed");
        end else begin
            $display("gf2m_poly_divider_top test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("gf2m_poly_divider_top test failed");
        $finish;
    end

endmodule
